// ----- design/window_id_map_classifier_unit_macros.svh -----
`ifndef WINDOW_ID_MAP_CLASSIFIER_UNIT_MACROS_SVH
`define WINDOW_ID_MAP_CLASSIFIER_UNIT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define WIMC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define WIMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/wimc_pkg.sv -----
package wimc_pkg;

    localparam int RECT_W = 64;
    localparam int COORD_W = 16;
    localparam int PIXEL_W = 15;
    localparam int SLOT_W = 4;
    localparam int COUNT_W = 5;
    localparam int BORDER_W = 8;
    localparam int WORD_W = 32;
    localparam int ID_SHIFT = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic CFG_WINDOW_COUNT = 1'b0;
    localparam logic CFG_BORDER_WIDTH = 1'b1;

    localparam logic [COUNT_W-1:0] WINDOW_COUNT_RESET = 5'd0;
    localparam logic [BORDER_W-1:0] BORDER_WIDTH_RESET = 8'd4;

    localparam logic [WORD_W-1:0] FLAG_WINDOW = 32'd1;
    localparam logic [WORD_W-1:0] FLAG_BORDER = 32'd2;

    typedef struct packed {
        logic                  is_load;
        logic [SLOT_W-1:0]     slot;
        logic [RECT_W-1:0]     rect;
        logic [PIXEL_W-1:0]    px;
        logic [PIXEL_W-1:0]    py;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  window_count;
        logic [BORDER_W-1:0] border_width;
    } cfg_t;

endpackage

// ----- design/wimc_req_if.sv -----
interface wimc_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [3:0]         window_index;
    logic signed [15:0] win_min_x;
    logic signed [15:0] win_min_y;
    logic signed [15:0] win_max_x;
    logic signed [15:0] win_max_y;
    logic [14:0]        pixel_x;
    logic [14:0]        pixel_y;

    modport source (
        output valid, op, window_index, win_min_x, win_min_y, win_max_x, win_max_y,
               pixel_x, pixel_y,
        input  ready
    );

    modport sink (
        input  valid, op, window_index, win_min_x, win_min_y, win_max_x, win_max_y,
               pixel_x, pixel_y,
        output ready
    );
endinterface

// ----- design/wimc_rsp_if.sv -----
interface wimc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] info_word;
    logic        in_window;
    logic        on_border;

    modport source (
        output valid, info_word, in_window, on_border,
        input  ready
    );

    modport sink (
        input  valid, info_word, in_window, on_border,
        output ready
    );
endinterface

// ----- design/wimc_ram.sv -----
module wimc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/wimc_front.sv -----
module wimc_front (
    input  logic          clk,
    input  logic          rst_n,
    wimc_req_if.sink      request,
    output wimc_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);

    import wimc_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    cmd_t        incoming;

    assign request.ready = (count_reg != 2'd2);
    assign push = request.valid && request.ready;
    assign pop = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.is_load = (request.op == OP_LOAD);
        incoming.slot = request.window_index;
        incoming.rect = {request.win_min_x, request.win_min_y,
                         request.win_max_x, request.win_max_y};
        incoming.px = request.pixel_x;
        incoming.py = request.pixel_y;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- design/wimc_back.sv -----
module wimc_back #(
    parameter int MAX_WINDOWS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wimc_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  wimc_pkg::cfg_t cfg,
    wimc_rsp_if.source     response
);

    import wimc_pkg::*;

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNTW = $clog2(MAX_WINDOWS + 1) + COUNT_W;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [PIXEL_W-1:0]  px_reg;
    logic [PIXEL_W-1:0]  px_next;
    logic [PIXEL_W-1:0]  py_reg;
    logic [PIXEL_W-1:0]  py_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   out_word_reg;
    logic [WORD_W-1:0]   out_word_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [RECT_W-1:0]   ram_rdata;
    logic [CNTW-1:0]     slot_ext;
    logic                slot_ok;
    logic [CNTW-1:0]     count_ext;
    logic [CNTW-1:0]     n_sat;
    logic                n_zero;
    logic                last;
    logic                out_free;
    logic                load_out;
    logic [WORD_W-1:0]   word_new;

    logic signed [17:0]  x0;
    logic signed [17:0]  y0;
    logic signed [17:0]  x1;
    logic signed [17:0]  y1;
    logic signed [17:0]  pxs;
    logic signed [17:0]  pys;
    logic signed [17:0]  bws;
    logic signed [17:0]  id;
    logic [WORD_W-1:0]   id_word;
    logic                hit;
    logic                border;
    logic [WORD_W-1:0]   hit_word;

    assign slot_ext = CNTW'(cmd.slot);
    assign slot_ok = (slot_ext < CNTW'(MAX_WINDOWS));
    assign ram_waddr = slot_ext[AW-1:0];
    assign count_ext = CNTW'(cfg.window_count);
    assign n_sat = (count_ext > CNTW'(MAX_WINDOWS)) ? CNTW'(MAX_WINDOWS) : count_ext;
    assign n_zero = (n_sat == '0);
    assign last = ((CNTW'(idx_reg) + CNTW'(1)) == n_sat);
    assign out_free = !out_valid_reg || response.ready;

    assign x0 = 18'(signed'(ram_rdata[63:48]));
    assign y0 = 18'(signed'(ram_rdata[47:32]));
    assign x1 = 18'(signed'(ram_rdata[31:16]));
    assign y1 = 18'(signed'(ram_rdata[15:0]));
    assign pxs = signed'(18'(px_reg));
    assign pys = signed'(18'(py_reg));
    assign bws = signed'(18'(cfg.border_width));
    assign id = x0 + y0 + x1 + y1;
    assign id_word = WORD_W'(id);
    assign hit = (pxs >= x0) && (pxs < x1) && (pys >= y0) && (pys < y1);
    assign border = (pxs < x0 + bws) || (pxs >= x1 - bws) ||
                    (pys < y0 + bws) || (pys >= y1 - bws);
    assign hit_word = (id_word << ID_SHIFT) | FLAG_WINDOW | (border ? FLAG_BORDER : '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        px_next = px_reg;
        py_next = py_reg;
        ram_raddr = idx_reg;
        ram_we = 1'b0;
        cmd_pop = 1'b0;
        load_out = 1'b0;
        word_new = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (cmd_valid)
                begin
                    if (cmd.is_load)
                    begin
                        ram_we = slot_ok;
                        cmd_pop = 1'b1;
                    end
                    else if (n_zero)
                    begin
                        if (out_free)
                        begin
                            load_out = 1'b1;
                            word_new = FLAG_WINDOW;
                            cmd_pop = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                        px_next = cmd.px;
                        py_next = cmd.py;
                        idx_next = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        load_out = 1'b1;
                        word_new = hit_word;
                        state_next = S_IDLE;
                    end
                end
                else if (last)
                begin
                    if (out_free)
                    begin
                        load_out = 1'b1;
                        word_new = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    ram_raddr = idx_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next = out_word_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_word_next = word_new;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        px_reg <= px_next;
        py_reg <= py_next;
        out_word_reg <= out_word_next;
    end

    wimc_ram #(
        .WIDTH(RECT_W),
        .DEPTH(MAX_WINDOWS)
    ) u_rect_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(cmd.rect),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign response.valid = out_valid_reg;
    assign response.info_word = out_word_reg;
    assign response.in_window = out_word_reg[0];
    assign response.on_border = out_word_reg[1];

endmodule

// ----- design/window_id_map_classifier_unit.sv -----
// A load item is popped by the back end as soon as it is idle, so a load can be accepted
// every cycle while the queue is not full. A classify item reads one slot per cycle and
// stops at the first hit: with n = min(window_count, MAX_WINDOWS) it stops after slot
// n - 1 at the latest, and it reads no slot when n is zero.
// Reset clears the queue, the output valid flag and the configuration registers
// (window_count 0, border_width 4); the slot memory is not cleared.
module window_id_map_classifier_unit #(
    parameter int MAX_WINDOWS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    wimc_req_if.sink    request,
    wimc_rsp_if.source  response,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    import wimc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WINDOW_COUNT: cfg_next.window_count = cfg_data[COUNT_W-1:0];
                CFG_BORDER_WIDTH: cfg_next.border_width = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_count <= WINDOW_COUNT_RESET;
            cfg_reg.border_width <= BORDER_WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wimc_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .request(request),
        .cmd(cmd),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop)
    );

    wimc_back #(
        .MAX_WINDOWS(MAX_WINDOWS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop),
        .cfg(cfg_reg),
        .response(response)
    );

endmodule

// ----- design/wimc_checker.sv -----
`include "window_id_map_classifier_unit_macros.svh"

module wimc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] info_word,
    input logic        in_window,
    input logic        on_border
);

    `WIMC_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(info_word), "response item changed while stalled")
    `WIMC_ASSERT_CLK(a_flags_match, rsp_valid |-> (in_window == info_word[0]) && (on_border == info_word[1]), "flag outputs disagree with info_word")
    `WIMC_ASSERT_CLK(a_miss_zero, rsp_valid && !in_window |-> (info_word == 32'd0) && !on_border, "a miss must give an all-zero item")
    `WIMC_ASSERT_ALWAYS(a_reset_exit, rst_n && !$past(rst_n) |-> req_ready && !rsp_valid, "block not empty after reset")

endmodule

bind window_id_map_classifier_unit wimc_checker u_wimc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_ready(request.ready),
    .rsp_valid(response.valid),
    .rsp_ready(response.ready),
    .info_word(response.info_word),
    .in_window(response.in_window),
    .on_border(response.on_border)
);
